// File: rtl/core/dlts_pkg.sv
// Shared types and constants for the delta-list task scheduler.
// No dependencies; compiled first.
`default_nettype none

package dlts_pkg;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int OP_W    = 2;
  localparam int TASK_W  = 8;
  localparam int DELTA_W = 16;
  localparam int PER_W   = 8;
  localparam int PEND_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DISPATCH = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_INSERT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the accepted item
    logic tick;      // age the head slot
    logic full;      // flag dropped add
    logic fire;      // report and remove the head
    logic step;      // walk past one slot
    logic adjust;    // reduce the delta of the slot at the insertion point
    logic insert;    // shift up and write the new slot
    logic out_load;  // move result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            head_due;
    logic            per_nz;
    logic            walk_stop;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/dlts_if.sv
// Valid/ready channel interfaces for the scheduler's item and result streams.
// Depends on dlts_pkg for field widths.
`default_nettype none

interface dlts_in_if
  import dlts_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [TASK_W-1:0]  task_id;
  logic [DELTA_W-1:0] first_delay;
  logic [PER_W-1:0]   period;

  modport source (output valid, opcode, task_id, first_delay, period, input ready);
  modport sink   (input valid, opcode, task_id, first_delay, period, output ready);
endinterface

interface dlts_out_if
  import dlts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              fired;
  logic [TASK_W-1:0] fired_task;
  logic              status;

  modport source (output valid, fired, fired_task, status, input ready);
  modport sink   (input valid, fired, fired_task, status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dlts_ctrl.sv
// Sequencing FSM of the scheduler: accept, execute, walk, insert, respond.
// Depends on dlts_pkg; drives dlts_dp through dp_cmd_t.
`default_nettype none

module dlts_ctrl
  import dlts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (stat.op)
          OP_ADD:      state_nxt = stat.full ? S_RESP : S_WALK;
          OP_DISPATCH: state_nxt = (stat.head_due && stat.per_nz) ? S_WALK : S_RESP;
          default:     state_nxt = S_RESP;
        endcase
      end
      S_WALK:   if (stat.walk_stop) state_nxt = S_INSERT;
      S_INSERT: state_nxt = S_RESP;
      S_RESP:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE:   cmd.load = in_valid;
      S_EXEC: begin
        cmd.tick = (stat.op == OP_TICK);
        cmd.full = (stat.op == OP_ADD) && stat.full;
        cmd.fire = (stat.op == OP_DISPATCH) && stat.head_due;
      end
      S_WALK: begin
        cmd.step   = !stat.walk_stop;
        cmd.adjust = stat.walk_stop;
      end
      S_INSERT: cmd.insert   = 1'b1;
      S_RESP:   cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execute");

  a_insert_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT) |=> (state_r == S_RESP))
    else $error("insert not followed by response");

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not delivered to free output register");

endmodule

`default_nettype wire

// File: rtl/core/dlts_dp.sv
// Slot table, walk registers and result registers of the scheduler.
// Depends on dlts_pkg; commanded by dlts_ctrl.
`default_nettype none

module dlts_dp
  import dlts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  input  wire logic [OP_W-1:0]    in_opcode,
  input  wire logic [TASK_W-1:0]  in_task_id,
  input  wire logic [DELTA_W-1:0] in_first_delay,
  input  wire logic [PER_W-1:0]   in_period,
  output logic                    out_fired,
  output logic [TASK_W-1:0]       out_fired_task,
  output logic                    out_status
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TASK_SLOTS);

  logic [TASK_W-1:0]  slot_task_r   [TASK_SLOTS];
  logic [DELTA_W-1:0] slot_delta_r  [TASK_SLOTS];
  logic [PER_W-1:0]   slot_period_r [TASK_SLOTS];
  logic [PEND_W-1:0]  slot_pend_r   [TASK_SLOTS];

  logic [CNT_W-1:0]   cnt_r;      // used slots sit at indices below cnt_r
  logic [CNT_W-1:0]   idx_r;      // walk position, insertion point at stop
  logic [OP_W-1:0]    op_r;
  logic [TASK_W-1:0]  id_r;
  logic [DELTA_W-1:0] rest_r;     // delay left after the slots walked past
  logic [PER_W-1:0]   per_r;
  logic               res_fired_r;
  logic [TASK_W-1:0]  res_task_r;
  logic               res_status_r;
  logic               out_fired_r;
  logic [TASK_W-1:0]  out_task_r;
  logic               out_status_r;

  logic [IDX_W-1:0]   idx_sel;
  logic               idx_in_use;
  logic [DELTA_W-1:0] walk_delta;

  assign idx_sel    = idx_r[IDX_W-1:0];
  assign idx_in_use = (idx_r < cnt_r);
  assign walk_delta = slot_delta_r[idx_sel];

  assign stat.op        = op_r;
  assign stat.full      = (cnt_r == FULL_CNT);
  assign stat.head_due  = (cnt_r != '0) && (slot_pend_r[0] != '0);
  assign stat.per_nz    = (slot_period_r[0] != '0);
  assign stat.walk_stop = !(idx_in_use && (walk_delta <= rest_r));

  // item and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r         <= in_opcode;
      id_r         <= in_task_id;
      rest_r       <= in_first_delay;
      per_r        <= in_period;
      idx_r        <= '0;
      res_fired_r  <= 1'b0;
      res_task_r   <= '0;
      res_status_r <= 1'b0;
    end
    if (cmd.full) res_status_r <= 1'b1;
    if (cmd.fire) begin
      // head leaves; a periodic task walks back in with its period as delay
      res_fired_r <= 1'b1;
      res_task_r  <= slot_task_r[0];
      id_r        <= slot_task_r[0];
      per_r       <= slot_period_r[0];
      rest_r      <= DELTA_W'(slot_period_r[0]);
      idx_r       <= '0;
    end
    if (cmd.step) begin
      rest_r <= rest_r - walk_delta;
      idx_r  <= idx_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_fired_r  <= res_fired_r;
      out_task_r   <= res_task_r;
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.fire) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (cmd.insert) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // one register set per slot; neighbors feed the shifts
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_slot
    localparam logic [CNT_W-1:0] I_C = CNT_W'(i);

    always_ff @(posedge clk) begin
      if (cmd.tick && i == 0 && cnt_r != '0) begin
        if (slot_delta_r[i] == '0) begin
          if (slot_pend_r[i] != '1) slot_pend_r[i] <= slot_pend_r[i] + PEND_W'(1);
        end else begin
          slot_delta_r[i] <= slot_delta_r[i] - DELTA_W'(1);
        end
      end
      if (cmd.fire) begin
        if (i < TASK_SLOTS - 1) begin
          slot_task_r[i]   <= slot_task_r[(i + 1) % TASK_SLOTS];
          slot_delta_r[i]  <= slot_delta_r[(i + 1) % TASK_SLOTS];
          slot_period_r[i] <= slot_period_r[(i + 1) % TASK_SLOTS];
          slot_pend_r[i]   <= slot_pend_r[(i + 1) % TASK_SLOTS];
        end
      end
      if (cmd.adjust && idx_r == I_C && idx_in_use)
        slot_delta_r[i] <= slot_delta_r[i] - rest_r;
      if (cmd.insert) begin
        if (idx_r == I_C) begin
          slot_task_r[i]   <= id_r;
          slot_delta_r[i]  <= rest_r;
          slot_period_r[i] <= per_r;
          slot_pend_r[i]   <= '0;
        end else if (i > 0 && idx_r < I_C && I_C <= cnt_r) begin
          slot_task_r[i]   <= slot_task_r[(i + TASK_SLOTS - 1) % TASK_SLOTS];
          slot_delta_r[i]  <= slot_delta_r[(i + TASK_SLOTS - 1) % TASK_SLOTS];
          slot_period_r[i] <= slot_period_r[(i + TASK_SLOTS - 1) % TASK_SLOTS];
          slot_pend_r[i]   <= slot_pend_r[(i + TASK_SLOTS - 1) % TASK_SLOTS];
        end
      end
    end
  end

  assign out_fired      = out_fired_r;
  assign out_fired_task = out_task_r;
  assign out_status     = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("slot count above table size");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> (cnt_r < FULL_CNT && idx_r <= cnt_r))
    else $error("insert into full table or past the end");

endmodule

`default_nettype wire

// File: rtl/core/delta_list_task_scheduler_unit.sv
// Delta-list task scheduler: one result item per input item (tick, add, dispatch).
// Depends on dlts_pkg, dlts_if, dlts_ctrl and dlts_dp.
`default_nettype none

// Timer queue of TASK_SLOTS slots kept sorted by due time, each slot holding
// its delay relative to the slot before it. A tick, a dispatch that re-adds
// nothing or an add dropped on a full table goes from accept through execute
// to respond; an add or a periodic re-add also walks past the slots before the
// insertion point (at most TASK_SLOTS - 1, since one slot is always free for
// the insert) and then inserts, the walk reading one slot delta per cycle
// through a single subtract and compare. A new item is accepted only once the
// previous one has finished; its result may still sit in the output register.
// A result held in the output register stalls the next item's response.
// Every item gives one result: fired and fired_task for a dispatch that found
// a due head task, status 1 for an add dropped on a full table. After reset
// the table is empty.
module delta_list_task_scheduler_unit
  import dlts_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  dlts_in_if.sink    in_ch,
  dlts_out_if.source out_ch
);

  dp_cmd_t  cmd;   // sequencing commands
  dp_stat_t stat;  // table and walk status

  dlts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dlts_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_opcode      (in_ch.opcode),
    .in_task_id     (in_ch.task_id),
    .in_first_delay (in_ch.first_delay),
    .in_period      (in_ch.period),
    .out_fired      (out_ch.fired),
    .out_fired_task (out_ch.fired_task),
    .out_status     (out_ch.status)
  );

endmodule

`default_nettype wire
